// ----- src/modexp_pkg.sv -----
// ----------------------------------------------------------------------------
// modexp_pkg - modular exponentiation core shared definitions
// Field widths and bit offsets of the stream beats.
// ----------------------------------------------------------------------------
`default_nettype none

package modexp_pkg;

	localparam int BASE_W     = 32;
	localparam int EXPONENT_W = 63;
	localparam int MODULUS_W  = 32;
	localparam int RESULT_W   = 32;

	localparam int BASE_LSB     = 0;
	localparam int EXPONENT_LSB = BASE_LSB + BASE_W;
	localparam int MODULUS_LSB  = EXPONENT_LSB + EXPONENT_W;

	localparam int IN_FIELDS_W = MODULUS_LSB + MODULUS_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

	// destination of a finished reduction
	typedef logic [1:0] target_t;
	localparam target_t TGT_BASE   = 2'd0;
	localparam target_t TGT_RESULT = 2'd1;
	localparam target_t TGT_SQUARE = 2'd2;

endpackage

`default_nettype wire

// ----- src/modular_exponentiation_core.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation_core - base^exponent mod modulus
// Right-to-left square-and-multiply with one shared multiplier and a
// bit-serial restoring remainder unit.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one job per beat (base, exponent, modulus). m_axis returns
//   one beat with the result. Beats move when tvalid and tready are high.
//   s_axis_tready is high only while the sequencer is idle; one job is
//   worked on at a time.
// Sequence:
//   The base is first reduced by the remainder unit. Each exponent bit
//   then costs one squaring, plus one multiply when the bit is set; every
//   multiply passes through loop, product register, load, OPERAND_WIDTH
//   remainder steps and write back, paced by the single remainder datapath
//   that retires one product bit per cycle. s_axis_tready returns in the
//   same cycle as result valid. A zero modulus skips every remainder pass,
//   the base reduction included, so each multiply then writes back
//   straight from the load state.
// Stall and reset:
//   The result waits in an output register; a new job is accepted while it
//   waits, and a finished job holds until that register is free.
//   arst_n clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_core #(
	parameter int OPERAND_WIDTH  = 32,
	parameter int EXPONENT_WIDTH = 63
) (
	input  wire  logic                                clk,
	input  wire  logic                                arst_n,
	input  wire  logic                                s_axis_tvalid,
	output logic                                      s_axis_tready,
	// base [31:0], exponent [94:32], modulus [126:95], zero pad [127]
	input  wire  logic [modexp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                                      m_axis_tvalid,
	input  wire  logic                                m_axis_tready,
	// power_result [31:0]
	output logic [modexp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

	localparam int W  = OPERAND_WIDTH;
	localparam int PW = 2 * OPERAND_WIDTH;
	localparam int EW = EXPONENT_WIDTH;
	localparam int BW = $clog2(EXPONENT_WIDTH + 1);
	localparam int SW = $clog2(OPERAND_WIDTH + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOP   = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_LOAD   = 3'd3;
	localparam logic [2:0] ST_REDUCE = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;

	logic [2:0]                state_q;
	logic [W-1:0]              mod_q;
	logic [W-1:0]              res_q;
	logic [W-1:0]              sq_q;
	logic [EW-1:0]             exp_q;
	logic [BW-1:0]             bits_q;
	logic                      phase_q;
	modexp_pkg::target_t       tgt_q;
	logic                      sel_sq_q;
	logic [PW-1:0]             prod_q;
	logic [W-1:0]              rem_q;
	logic [W-1:0]              low_q;
	logic [SW-1:0]             step_q;
	logic                      out_valid_q;
	logic [modexp_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic [W-1:0]  in_base;
	logic [W-1:0]  in_mod;
	logic [EW-1:0] in_exp;
	logic          in_fire;

	logic [W-1:0]  op_a;
	logic [PW-1:0] prod_d;
	logic [W:0]    shifted;
	logic [W+1:0]  diff;
	logic [W-1:0]  rem_next;
	logic          wb_fire;
	logic [W-1:0]  wb_val;
	logic          out_free;

	assign in_base = s_axis_tdata[modexp_pkg::BASE_LSB +: W];
	assign in_exp  = s_axis_tdata[modexp_pkg::EXPONENT_LSB +: EW];
	assign in_mod  = s_axis_tdata[modexp_pkg::MODULUS_LSB +: W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign out_free      = !out_valid_q || m_axis_tready;

	// shared multiplier
	assign op_a   = sel_sq_q ? sq_q : res_q;
	assign prod_d = PW'(op_a) * PW'(sq_q);

	// one restoring remainder step
	assign shifted  = {rem_q, low_q[W-1]};
	assign diff     = {1'b0, shifted} - {2'b00, mod_q};
	assign rem_next = diff[W+1] ? shifted[W-1:0] : diff[W-1:0];

	assign wb_fire = ((state_q == ST_LOAD) && (mod_q == '0)) ||
	                 ((state_q == ST_REDUCE) && (step_q == '0));
	assign wb_val  = (state_q == ST_LOAD) ? prod_q[W-1:0] : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			mod_q       <= '0;
			res_q       <= '0;
			sq_q        <= '0;
			exp_q       <= '0;
			bits_q      <= '0;
			phase_q     <= 1'b0;
			tgt_q       <= modexp_pkg::TGT_BASE;
			sel_sq_q    <= 1'b0;
			prod_q      <= '0;
			rem_q       <= '0;
			low_q       <= '0;
			step_q      <= '0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						mod_q   <= in_mod;
						exp_q   <= in_exp;
						res_q   <= W'(1);
						bits_q  <= BW'(EW);
						phase_q <= 1'b0;
						if (in_mod == '0) begin
							sq_q    <= in_base;
							state_q <= ST_LOOP;
						end else begin
							rem_q   <= '0;
							low_q   <= in_base;
							step_q  <= SW'(W);
							tgt_q   <= modexp_pkg::TGT_BASE;
							state_q <= ST_REDUCE;
						end
					end
				end
				ST_LOOP: begin
					if (bits_q == '0) begin
						state_q <= ST_FIN;
					end else if (!phase_q && exp_q[0]) begin
						sel_sq_q <= 1'b0;
						tgt_q    <= modexp_pkg::TGT_RESULT;
						state_q  <= ST_MUL;
					end else begin
						sel_sq_q <= 1'b1;
						tgt_q    <= modexp_pkg::TGT_SQUARE;
						state_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= prod_d;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					// high half is already below the modulus
					if (mod_q != '0) begin
						rem_q   <= prod_q[PW-1:W];
						low_q   <= prod_q[W-1:0];
						step_q  <= SW'(W);
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (step_q != '0) begin
						rem_q  <= rem_next;
						low_q  <= {low_q[W-2:0], 1'b0};
						step_q <= step_q - SW'(1);
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_data_q  <= modexp_pkg::OUT_TDATA_W'(res_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (wb_fire) begin
				state_q <= ST_LOOP;
				case (tgt_q)
					modexp_pkg::TGT_BASE: begin
						sq_q <= wb_val;
					end
					modexp_pkg::TGT_RESULT: begin
						res_q   <= wb_val;
						phase_q <= 1'b1;
					end
					modexp_pkg::TGT_SQUARE: begin
						sq_q    <= wb_val;
						exp_q   <= exp_q >> 1;
						bits_q  <= bits_q - BW'(1);
						phase_q <= 1'b0;
					end
					default: begin
						sq_q <= wb_val;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- bench/modular_exponentiation_core_tb.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation_core_tb - self-checking bench for the modexp core
// A table of directed jobs (zero exponents, unit and zero moduli, full-width
// operands, the top exponent bit) is followed by constrained-by-hand random
// jobs. Expected powers come from the table or from a square-and-multiply
// model in the bench; each result beat is compared in order against them.
// Both stream sides idle at random, with one stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_JOBS = 110;
	localparam int CYCLE_LIMIT = 4_000_000;

	typedef logic [modexp_pkg::BASE_W-1:0]     operand_t;
	typedef logic [modexp_pkg::EXPONENT_W-1:0] exponent_t;
	typedef logic [modexp_pkg::RESULT_W-1:0]   power_t;

	typedef struct packed {
		operand_t  base;
		exponent_t exponent;
		operand_t  modulus;
		logic      known;
		power_t    power;
	} job_row_t;

	typedef struct {
		int     tag;
		power_t power;
	} pending_t;

	localparam exponent_t EXP_MAX = '1;
	localparam exponent_t EXP_TOP = {1'b1, {(modexp_pkg::EXPONENT_W-1){1'b0}}};

	// base, exponent, modulus, known, power
	job_row_t job_table [0:20] = '{
		'{32'h0000_0000, 63'd0,     32'd1,         1'b1, 32'd1},
		'{32'hFFFF_FFFF, 63'd0,     32'hFFFF_FFFF, 1'b1, 32'd1},
		'{32'd5,         63'd1,     32'd1,         1'b1, 32'd0},
		'{32'd0,         63'd5,     32'd7,         1'b1, 32'd0},
		'{32'd2,         63'd10,    32'd1000,      1'b1, 32'd24},
		'{32'd3,         63'd4,     32'hFFFF_FFFF, 1'b1, 32'd81},
		'{32'hFFFF_FFFF, 63'd1,     32'hFFFF_FFFF, 1'b1, 32'd0},
		'{32'hFFFF_FFFF, 63'd2,     32'hFFFF_FFFE, 1'b1, 32'd1},
		'{32'd2,         63'd31,    32'd0,         1'b1, 32'h8000_0000},
		'{32'd2,         63'd32,    32'd0,         1'b1, 32'd0},
		'{32'd3,         63'd0,     32'd0,         1'b1, 32'd1},
		'{32'hFFFF_FFFF, EXP_MAX,   32'd0,         1'b1, 32'hFFFF_FFFF},
		'{32'hFFFF_FFFF, EXP_MAX,   32'hFFFF_FFFF, 1'b1, 32'd0},
		'{32'hFFFF_FFFE, EXP_MAX,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE},
		'{32'd7,         63'd1,     32'hFFFF_FFFB, 1'b1, 32'd7},
		'{32'hFFFF_FFFF, EXP_MAX,   32'hFFFF_FFFB, 1'b0, 32'd0},
		'{32'h075B_CD15, 63'd65537, 32'hFFFF_FFFB, 1'b0, 32'd0},
		'{32'd1,         EXP_MAX,   32'd2,         1'b1, 32'd1},
		'{32'h8000_0000, 63'd2,     32'hFFFF_FFFF, 1'b1, 32'h4000_0000},
		'{32'd10,        63'd3,     32'd7,         1'b1, 32'd6},
		'{32'd3,         EXP_TOP,   32'hFFFF_FFFB, 1'b0, 32'd0}
	};

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               s_axis_tvalid = 1'b0;
	logic                               s_axis_tready;
	logic [modexp_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                               m_axis_tvalid;
	logic                               m_axis_tready = 1'b0;
	logic [modexp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	pending_t pending_power [$];
	int       jobs_sent = 0;
	int       mismatches = 0;
	int       cycle_count = 0;
	logic     quiet = 1'b0;

	modular_exponentiation_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// a zero modulus means no reduction: wrap at the operand width
	function automatic logic [63:0] fold(input logic [63:0] value, input operand_t modulus);
		if (modulus == '0) begin
			return {32'd0, value[31:0]};
		end
		return value % {32'd0, modulus};
	endfunction

	function automatic power_t mod_power(input operand_t base, input exponent_t exponent,
			input operand_t modulus);
		logic [63:0] square;
		logic [63:0] acc;
		square = fold({32'd0, base}, modulus);
		acc = 64'd1;
		for (int i = 0; i < modexp_pkg::EXPONENT_W; i++) begin
			if (exponent[i]) begin
				acc = fold(acc * square, modulus);
			end
			square = fold(square * square, modulus);
		end
		return acc[31:0];
	endfunction

	task automatic send_job(input operand_t base, input exponent_t exponent, input operand_t modulus,
			input logic known, input power_t power);
		logic [modexp_pkg::IN_TDATA_W-1:0] beat;
		pending_t                          entry;
		beat = '0;
		beat[modexp_pkg::BASE_LSB +: modexp_pkg::BASE_W] = base;
		beat[modexp_pkg::EXPONENT_LSB +: modexp_pkg::EXPONENT_W] = exponent;
		beat[modexp_pkg::MODULUS_LSB +: modexp_pkg::MODULUS_W] = modulus;
		entry.tag = jobs_sent;
		entry.power = known ? power : mod_power(base, exponent, modulus);
		while (!quiet && $urandom_range(0, 99) < 36) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= beat;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		pending_power.push_back(entry);
		jobs_sent++;
	endtask

	always @(posedge clk) begin
		m_axis_tready <= quiet || ($urandom_range(0, 99) >= 36);
	end

	always @(posedge clk) begin
		pending_t entry;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_power.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result beat: power_result %h",
						m_axis_tdata[modexp_pkg::RESULT_W-1:0]);
				end
			end else begin
				entry = pending_power.pop_front();
				if (m_axis_tdata[modexp_pkg::RESULT_W-1:0] !== entry.power) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("job %0d power_result: expected %h, got %h", entry.tag,
							entry.power, m_axis_tdata[modexp_pkg::RESULT_W-1:0]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("modular_exponentiation_core regression: fail");
			$finish;
		end
	end

	initial begin
		operand_t    base;
		operand_t    modulus;
		exponent_t   exponent;
		logic [63:0] wide;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (job_table[i]) begin
			send_job(job_table[i].base, job_table[i].exponent, job_table[i].modulus,
				job_table[i].known, job_table[i].power);
		end

		for (int n = 0; n < RANDOM_JOBS; n++) begin
			quiet = (n >= 50 && n < 80);
			case ($urandom_range(0, 7))
				0: base = '0;
				1: base = '1;
				default: base = $urandom;
			endcase
			wide = {$urandom, $urandom};
			case ($urandom_range(0, 7))
				0: exponent = '0;
				1, 2: exponent = exponent_t'(wide[5:0]);
				default: exponent = wide[modexp_pkg::EXPONENT_W-1:0];
			endcase
			case ($urandom_range(0, 15))
				0: modulus = 32'd1;
				1: modulus = '0;
				2, 3: modulus = $urandom_range(2, 16);
				4: modulus = '1;
				default: begin
					modulus = $urandom;
					if (modulus == '0) begin
						modulus = 32'd1;
					end
				end
			endcase
			send_job(base, exponent, modulus, 1'b0, '0);
		end
		quiet = 1'b0;
		s_axis_tvalid <= 1'b0;

		while (pending_power.size() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);

		if (mismatches == 0) begin
			$display("modular_exponentiation_core regression: pass");
		end else begin
			$display("modular_exponentiation_core regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
